// File: rtl/mmes_pkg.sv
// Package for the min/max envelope tracker: snapshot record types, word
// layouts of both channels and the bank command struct. No dependencies.
package mmes_pkg;

  localparam logic [15:0] MAG_MASK = 16'h7fff;

  // one captured triple
  typedef struct packed {
    logic [15:0] ten;
    logic [15:0] ang;
    logic [15:0] tlt;
  } snap_t;

  // the four snapshot records of one channel
  typedef struct packed {
    snap_t hi_t;
    snap_t lo_t;
    snap_t hi_d;
    snap_t lo_d;
  } rec_set_t;

  typedef struct packed {
    logic [1:0]  channel;
    logic        restart;
    logic [15:0] tension;
    logic        tension_ok;
    logic [15:0] deflection;
    logic        deflection_ok;
    logic [15:0] tilt;
  } in_word_t;

  typedef struct packed {
    logic [15:0] hi_t_tension;
    logic [15:0] hi_t_deflection;
    logic [15:0] hi_t_tilt;
    logic [15:0] lo_t_tension;
    logic [15:0] lo_t_deflection;
    logic [15:0] lo_t_tilt;
    logic [15:0] hi_d_tension;
    logic [15:0] hi_d_deflection;
    logic [15:0] hi_d_tilt;
    logic [15:0] lo_d_tension;
    logic [15:0] lo_d_deflection;
    logic [15:0] lo_d_tilt;
  } out_word_t;

  // write/clear command to the record bank
  typedef struct packed {
    logic write;
    logic clear;
  } bank_cmd_t;

endpackage

// File: rtl/mmes_if.sv
// Valid/ready channel interfaces for sample words and envelope words.
// Depends on mmes_pkg for the word layouts.
interface mmes_in_if import mmes_pkg::*; ();
  logic     valid;
  logic     ready;
  in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mmes_out_if import mmes_pkg::*; ();
  logic      valid;
  logic      ready;
  out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/min_max_envelope_with_snapshot_top.sv
// Min/max envelope tracker with snapshot capture, top level.
// A word passes through the input register and then the output register.
// Throughput: one word per cycle while the envelope receiver keeps ready high; the
// record read-modify-write of one channel closes within the single update stage.
// Reset (synchronous, rst high): clears valids and all loaded flags.
// Depends on mmes_pkg, mmes_if, mmes_update and mmes_bank.
module min_max_envelope_with_snapshot_top import mmes_pkg::*; #(
  parameter int CHANNELS = 3
) (
  input logic         clk,
  input logic         rst,
  mmes_in_if.sink     samples,
  mmes_out_if.source  envelope
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // input register stage
  logic     s1_valid;
  in_word_t s1_data;

  // output register
  logic      out_valid;
  out_word_t out_data;

  logic out_free;
  logic s1_adv;
  logic in_ready;

  logic [31:0]         ch_wide;
  logic                in_range;
  logic [IDX_W-1:0]    idx;
  logic                first;
  snap_t               sample;
  rec_set_t            cur;
  rec_set_t            nxt;
  bank_cmd_t           cmd;
  logic [CHANNELS-1:0] bank_loaded;

  // Output register frees when empty or being taken; the input register
  // moves on whenever the output register can take its result, so a word
  // can enter every cycle.
  assign out_free = !out_valid || envelope.ready;
  assign s1_adv   = s1_valid && out_free;
  assign in_ready = !s1_valid || out_free;
  assign samples.ready = in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= samples.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && samples.valid) begin
      s1_data <= samples.data;
    end
  end

  // channel decode: the index only needs enough bits for the bank depth
  assign ch_wide  = {30'd0, s1_data.channel};
  assign in_range = ch_wide < 32'(CHANNELS);
  assign idx      = ch_wide[IDX_W-1:0];

  // a restart in this word unloads every channel before the update
  assign first = s1_data.restart || !bank_loaded[idx];

  assign sample.ten = s1_data.tension;
  assign sample.ang = s1_data.deflection;
  assign sample.tlt = s1_data.tilt;

  assign cmd.write = s1_adv && in_range;
  assign cmd.clear = s1_adv && s1_data.restart;

  mmes_bank #(
    .CHANNELS (CHANNELS),
    .IDX_W    (IDX_W)
  ) u_bank (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .idx     (idx),
    .wr_data (nxt),
    .rd_data (cur),
    .loaded  (bank_loaded)
  );

  mmes_update u_update (
    .first  (first),
    .sample (sample),
    .t_ok   (s1_data.tension_ok),
    .d_ok   (s1_data.deflection_ok),
    .cur    (cur),
    .nxt    (nxt)
  );

  // result register; an unknown channel returns an all-zero word
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      if (in_range) begin
        out_data.hi_t_tension    <= nxt.hi_t.ten;
        out_data.hi_t_deflection <= nxt.hi_t.ang;
        out_data.hi_t_tilt       <= nxt.hi_t.tlt;
        out_data.lo_t_tension    <= nxt.lo_t.ten;
        out_data.lo_t_deflection <= nxt.lo_t.ang;
        out_data.lo_t_tilt       <= nxt.lo_t.tlt;
        out_data.hi_d_tension    <= nxt.hi_d.ten;
        out_data.hi_d_deflection <= nxt.hi_d.ang;
        out_data.hi_d_tilt       <= nxt.hi_d.tlt;
        out_data.lo_d_tension    <= nxt.lo_d.ten;
        out_data.lo_d_deflection <= nxt.lo_d.ang;
        out_data.lo_d_tilt       <= nxt.lo_d.tlt;
      end else begin
        out_data <= '0;
      end
    end
  end

  assign envelope.valid = out_valid;
  assign envelope.data  = out_data;

  // a word leaving the input stage always lands in the output register
  a_adv_to_out: assert property (@(posedge clk) disable iff (rst)
    s1_adv |=> envelope.valid)
    else $error("processed word did not reach the output register");

  // an in-range update leaves at least one channel marked loaded
  a_loaded_set: assert property (@(posedge clk) disable iff (rst)
    s1_adv && in_range |=> bank_loaded != '0)
    else $error("channel not marked loaded after update");

  // restart with an unknown channel leaves every channel unloaded
  a_restart_clr: assert property (@(posedge clk) disable iff (rst)
    s1_adv && s1_data.restart && !in_range |=> bank_loaded == '0)
    else $error("restart did not clear loaded flags");

  // unknown channel gives an all-zero word
  a_zero_word: assert property (@(posedge clk) disable iff (rst)
    s1_adv && !in_range |=> envelope.data == '0)
    else $error("non-zero word for unknown channel");

endmodule

// File: rtl/mmes_update.sv
// Next-record logic for one channel: first-sample load, then max/min compare.
// Depends on mmes_pkg.
module mmes_update import mmes_pkg::*; (
  input  logic     first,
  input  snap_t    sample,
  input  logic     t_ok,
  input  logic     d_ok,
  input  rec_set_t cur,
  output rec_set_t nxt
);

  rec_set_t base;
  logic [15:0] mag;

  always_comb begin
    base = cur;
    if (first) begin
      base.hi_t = t_ok ? sample : '0;
      base.lo_t = t_ok ? sample : '0;
      base.hi_d = d_ok ? sample : '0;
      base.lo_d = d_ok ? sample : '0;
    end
  end

  assign mag = sample.ang & MAG_MASK;

  always_comb begin
    nxt = base;
    if (t_ok) begin
      priority if (sample.ten > base.hi_t.ten) begin
        nxt.hi_t = sample;
      end else if (sample.ten < base.lo_t.ten) begin
        nxt.lo_t = sample;
      end else begin
        // within the bounds, ties included: records unchanged
        nxt.lo_t = base.lo_t;
      end
    end
    if (d_ok) begin
      priority if (mag > (base.hi_d.ang & MAG_MASK)) begin
        nxt.hi_d = sample;
      end else if (mag < (base.lo_d.ang & MAG_MASK)) begin
        nxt.lo_d = sample;
      end else begin
        nxt.lo_d = base.lo_d;
      end
    end
  end

endmodule

// File: rtl/mmes_bank.sv
// Per-channel record store and loaded flags.
// Depends on mmes_pkg.
module mmes_bank import mmes_pkg::*; #(
  parameter int CHANNELS = 3,
  parameter int IDX_W    = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  bank_cmd_t           cmd,
  input  logic [IDX_W-1:0]    idx,
  input  rec_set_t            wr_data,
  output rec_set_t            rd_data,
  output logic [CHANNELS-1:0] loaded
);

  rec_set_t recs [CHANNELS];
  logic [CHANNELS-1:0] loaded_next;

  assign rd_data = recs[idx];

  // records are always written before use, so no reset
  always_ff @(posedge clk) begin
    if (cmd.write) begin
      recs[idx] <= wr_data;
    end
  end

  // clear first, then mark the written channel
  always_comb begin
    loaded_next = loaded;
    if (cmd.clear) begin
      loaded_next = '0;
    end
    if (cmd.write) begin
      loaded_next[idx] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      loaded <= '0;
    end else begin
      loaded <= loaded_next;
    end
  end

endmodule

// File: bench/min_max_envelope_with_snapshot_top_tb.sv
// Testbench for the min/max envelope tracker: drives sample words, predicts each
// envelope word in a scoreboard class and checks them in order.
// Depends on mmes_pkg, mmes_if and min_max_envelope_with_snapshot_top.
module min_max_envelope_with_snapshot_top_tb;
  import mmes_pkg::*;

  localparam int         CHANNELS     = 3;
  localparam logic [1:0] OUT_OF_RANGE = 2'd3;     // channel index with no records
  localparam int         FIELDS       = 12;       // 16-bit fields per envelope word
  localparam int         RANDOM_ITEMS = 195;      // per idling phase
  localparam int         STALL_LIMIT  = 2000;     // cycles with no word moving
  localparam int         DRAIN_CYCLES = 4;        // margin after the scoreboard queue empties

  logic clk;
  logic rst;
  int   send_idle_pct;
  int   recv_stall_pct;
  int   stall_count;

  // Scoreboard: keeps its own copy of the per-channel records and a queue of
  // envelope words still owed by the block.
  class envelope_scoreboard;
    logic [CHANNELS-1:0] armed;          // channel has seen its first sample
    rec_set_t            env [CHANNELS];
    out_word_t           pending [$];
    int                  errors;
    string               field_tag [FIELDS] = '{
      "hi_t_tension", "hi_t_deflection", "hi_t_tilt",
      "lo_t_tension", "lo_t_deflection", "lo_t_tilt",
      "hi_d_tension", "hi_d_deflection", "hi_d_tilt",
      "lo_d_tension", "lo_d_deflection", "lo_d_tilt"};

    function new();
      armed  = '0;
      errors = 0;
    endfunction

    function void note_sample(in_word_t w);
      snap_t     s;
      out_word_t e;
      int        ch;
      s.ten = w.tension;
      s.ang = w.deflection;
      s.tlt = w.tilt;
      e     = '0;
      ch    = w.channel;
      // restart drops every channel, even when this word addresses none
      if (w.restart)
        armed = '0;
      if (ch < CHANNELS) begin
        if (!armed[ch]) begin
          armed[ch]   = 1'b1;
          env[ch].hi_t = w.tension_ok    ? s : '0;
          env[ch].lo_t = w.tension_ok    ? s : '0;
          env[ch].hi_d = w.deflection_ok ? s : '0;
          env[ch].lo_d = w.deflection_ok ? s : '0;
        end
        if (w.tension_ok) begin
          if (s.ten > env[ch].hi_t.ten)
            env[ch].hi_t = s;
          else if (s.ten < env[ch].lo_t.ten)
            env[ch].lo_t = s;
        end
        // angle compared on magnitude only, sign bit ignored
        if (w.deflection_ok) begin
          if ((s.ang & MAG_MASK) > (env[ch].hi_d.ang & MAG_MASK))
            env[ch].hi_d = s;
          else if ((s.ang & MAG_MASK) < (env[ch].lo_d.ang & MAG_MASK))
            env[ch].lo_d = s;
        end
        // record set and envelope word share the same field order
        e = out_word_t'(env[ch]);
      end
      pending.push_back(e);
    endfunction

    function void check_envelope(out_word_t got);
      out_word_t   want;
      logic [191:0] w_bits;
      logic [191:0] g_bits;
      int          i;
      if (pending.size() == 0) begin
        $display("%0t: unexpected envelope word, expected none, got %h", $time, got);
        errors++;
        return;
      end
      want   = pending.pop_front();
      w_bits = want;
      g_bits = got;
      for (i = 0; i < FIELDS; i++) begin
        if (w_bits[191 - 16*i -: 16] !== g_bits[191 - 16*i -: 16]) begin
          $display("%0t: %s mismatch, expected %h, got %h", $time, field_tag[i],
                   w_bits[191 - 16*i -: 16], g_bits[191 - 16*i -: 16]);
          errors++;
        end
      end
    endfunction
  endclass

  envelope_scoreboard sb = new();

  mmes_in_if  samples_if ();
  mmes_out_if envelope_if ();

  min_max_envelope_with_snapshot_top #(
    .CHANNELS (CHANNELS)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .samples  (samples_if),
    .envelope (envelope_if)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: ready redrawn at every falling edge, stall rate set per phase.
  initial begin
    envelope_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      envelope_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor and watchdog. Input words are noted before output words are
  // checked in the same edge, so the queue is always in order.
  always @(posedge clk) begin
    if (rst) begin
      stall_count = 0;
    end else begin
      if (samples_if.valid && samples_if.ready)
        sb.note_sample(samples_if.data);
      if (envelope_if.valid && envelope_if.ready)
        sb.check_envelope(envelope_if.data);
      if ((samples_if.valid && samples_if.ready) ||
          (envelope_if.valid && envelope_if.ready))
        stall_count = 0;
      else
        stall_count++;
      if (stall_count >= STALL_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Readings biased towards the compare boundaries: zero, full scale, the
  // magnitude limit, negative zero and small values that often tie.
  function automatic logic [15:0] pick_reading();
    case ($urandom_range(9))
      0:       return 16'h0000;
      1:       return 16'hffff;
      2:       return 16'h7fff;
      3:       return 16'h8000;
      4:       return 16'($urandom_range(15));
      5:       return 16'h8000 | 16'($urandom_range(15));
      default: return 16'($urandom);
    endcase
  endfunction

  // Offer one word, with random idle cycles first; returns once accepted.
  task automatic send_sample(input in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      samples_if.valid <= 1'b0;
    end
    @(negedge clk);
    samples_if.valid <= 1'b1;
    samples_if.data  <= w;
    do
      @(posedge clk);
    while (!samples_if.ready);
  endtask

  task automatic put_sample(input logic [1:0] ch, input logic rs,
                            input logic [15:0] ten, input logic ten_ok,
                            input logic [15:0] ang, input logic ang_ok,
                            input logic [15:0] tlt);
    in_word_t w;
    w.channel       = ch;
    w.restart       = rs;
    w.tension       = ten;
    w.tension_ok    = ten_ok;
    w.deflection    = ang;
    w.deflection_ok = ang_ok;
    w.tilt          = tlt;
    send_sample(w);
  endtask

  initial begin
    in_word_t w;
    int       phase;
    int       n;
    rst              = 1'b1;
    samples_if.valid = 1'b0;
    samples_if.data  = '0;
    send_idle_pct    = 29;
    recv_stall_pct   = 50;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // --- directed words ---
    // first word of a window, full-scale readings everywhere
    put_sample(2'd0, 1'b1, 16'hffff, 1'b1, 16'hffff, 1'b1, 16'hffff);
    // new minima on both tension and angle
    put_sample(2'd0, 1'b0, 16'h0000, 1'b1, 16'h0000, 1'b1, 16'h0000);
    // ties: same tension max, same magnitude with the sign bit clear
    put_sample(2'd0, 1'b0, 16'hffff, 1'b1, 16'h7fff, 1'b1, 16'h1234);
    // ties at the bottom: negative zero has magnitude zero
    put_sample(2'd0, 1'b0, 16'h0000, 1'b1, 16'h8000, 1'b1, 16'h5555);
    // both reads failed, nothing may change
    put_sample(2'd0, 1'b0, 16'h8000, 1'b0, 16'h4000, 1'b0, 16'haaaa);
    // first word of a channel with both reads failed loads zero records
    put_sample(2'd1, 1'b0, 16'h1234, 1'b0, 16'h4321, 1'b0, 16'h0f0f);
    put_sample(2'd1, 1'b0, 16'h0010, 1'b1, 16'h8010, 1'b1, 16'hffff);
    // angle capture carrying a failed tension as companion
    put_sample(2'd1, 1'b0, 16'h0020, 1'b0, 16'h0030, 1'b1, 16'h00ff);
    // tension capture carrying a failed angle as companion
    put_sample(2'd1, 1'b0, 16'h0040, 1'b1, 16'h0001, 1'b0, 16'h7f7f);
    // first word with only the tension valid
    put_sample(2'd2, 1'b0, 16'h8000, 1'b1, 16'h7abc, 1'b0, 16'h0f0f);
    put_sample(2'd2, 1'b0, 16'h7fff, 1'b1, 16'h0005, 1'b1, 16'hf0f0);
    put_sample(2'd2, 1'b0, 16'h9000, 1'b1, 16'h8003, 1'b1, 16'h0000);
    put_sample(2'd2, 1'b0, 16'h9000, 1'b1, 16'hffff, 1'b1, 16'h3c3c);
    // channel out of range returns zeros; with restart it still clears all
    put_sample(OUT_OF_RANGE, 1'b0, 16'hffff, 1'b1, 16'hffff, 1'b1, 16'hffff);
    put_sample(OUT_OF_RANGE, 1'b1, 16'h5a5a, 1'b1, 16'ha5a5, 1'b1, 16'h1111);
    // every channel reloads after that restart
    put_sample(2'd0, 1'b0, 16'h1111, 1'b1, 16'h2222, 1'b1, 16'h3333);
    put_sample(2'd1, 1'b0, 16'h4444, 1'b0, 16'hc444, 1'b1, 16'h5555);
    put_sample(2'd2, 1'b0, 16'h0001, 1'b1, 16'h8001, 1'b1, 16'hfffe);
    // restart on an in-range word reloads that channel at once
    put_sample(2'd0, 1'b1, 16'h7777, 1'b1, 16'hf777, 1'b1, 16'h8888);
    put_sample(2'd0, 1'b0, 16'h7778, 1'b1, 16'h7776, 1'b1, 16'h9999);
    put_sample(2'd0, 1'b0, 16'h7776, 1'b1, 16'hf778, 1'b1, 16'haaaa);
    put_sample(2'd1, 1'b0, 16'h0000, 1'b1, 16'h8000, 1'b1, 16'h0000);

    // --- random words, three idling phases ---
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 29;
          recv_stall_pct = 50;
        end
        1: begin
          send_idle_pct  = 50;
          recv_stall_pct = 29;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      for (n = 0; n < RANDOM_ITEMS; n++) begin
        // mostly in-range channels with valid reads; restarts are rare so
        // windows run long enough for the envelopes to settle
        w.channel       = ($urandom_range(19) == 0) ? OUT_OF_RANGE
                                                    : 2'($urandom_range(CHANNELS - 1));
        w.restart       = ($urandom_range(31) == 0);
        w.tension       = pick_reading();
        w.tension_ok    = ($urandom_range(7) != 0);
        w.deflection    = pick_reading();
        w.deflection_ok = ($urandom_range(7) != 0);
        w.tilt          = pick_reading();
        send_sample(w);
      end
    end

    @(negedge clk);
    samples_if.valid <= 1'b0;
    while (sb.pending.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

// File: sim.f
rtl/mmes_pkg.sv
rtl/mmes_if.sv
rtl/mmes_update.sv
rtl/mmes_bank.sv
rtl/min_max_envelope_with_snapshot_top.sv
bench/min_max_envelope_with_snapshot_top_tb.sv
